// ===== hw/rtl/fav_pkg.sv =====
// Shared constants, codes and types for the frame allocator with LRU victim choice.
package fav_pkg;

  localparam int DefFrames   = 32;
  localparam int DefAgeWidth = 16;

  localparam int ActionW = 3;
  localparam int PageW   = 5;
  localparam int OwnerW  = 8;
  localparam int AgeInW  = 16;
  localparam int FrameW  = 6;

  localparam logic [FrameW-1:0] NoFrame = '1;

  typedef enum logic [ActionW-1:0] {
    ActAlloc    = 3'd0,
    ActAllocOwn = 3'd1,
    ActFree     = 3'd2,
    ActQuery    = 3'd3,
    ActVictim   = 3'd4,
    ActSetAge   = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StWait
  } state_e;

  // command broadcast to every cell for the whole scan
  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [PageW-1:0]   page;
    logic [OwnerW-1:0]  owner;
  } cmd_t;

  // flags of the search record that walks the chain
  typedef struct packed {
    logic valid;
    logic found;
    logic q_used;
  } rec_ctl_t;

endpackage

// ===== hw/rtl/fav_if.sv =====
// Request and response channel interfaces of the frame allocator.
interface fav_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [4:0] page;
  logic [7:0] owner;
  logic [15:0] age;

  modport source (output valid, action, page, owner, age, input ready);
  modport sink   (input valid, action, page, owner, age, output ready);
endinterface

interface fav_rsp_if;
  logic              valid;
  logic              ready;
  logic signed [5:0] frame;
  logic              is_used;
  logic [7:0]        frame_owner;
  logic [5:0]        free_count;
  logic              any_free;

  modport source (output valid, frame, is_used, frame_owner, free_count, any_free,
                  input ready);
  modport sink   (input valid, frame, is_used, frame_owner, free_count, any_free,
                  output ready);
endinterface

// ===== hw/rtl/fav_cell.sv =====
// One frame slot: holds the frame state and updates the passing search record.
module fav_cell #(
  parameter int Frames   = fav_pkg::DefFrames,
  parameter int AgeWidth = fav_pkg::DefAgeWidth,
  parameter int Idx      = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fav_pkg::cmd_t                    cmd_i,
  input  logic [AgeWidth-1:0]              cmd_age_i,
  input  fav_pkg::rec_ctl_t                ctl_i,
  input  logic [$clog2(Frames)-1:0]        idx_i,
  input  logic [AgeWidth-1:0]              age_i,
  input  logic [fav_pkg::OwnerW-1:0]       owner_i,
  input  logic [$clog2(Frames+1)-1:0]      cnt_i,
  output fav_pkg::rec_ctl_t                ctl_o,
  output logic [$clog2(Frames)-1:0]        idx_o,
  output logic [AgeWidth-1:0]              age_o,
  output logic [fav_pkg::OwnerW-1:0]       owner_o,
  output logic [$clog2(Frames+1)-1:0]      cnt_o
);
  import fav_pkg::*;

  localparam int IdxW = $clog2(Frames);
  localparam int CntW = $clog2(Frames + 1);

  logic              used_q, used_d;
  logic              bound_q, bound_d;
  logic [OwnerW-1:0] own_q, own_d;
  logic [AgeWidth-1:0] age_q, age_d;

  rec_ctl_t          ctl_d, ctl_q;
  logic [IdxW-1:0]   idx_d, idx_q;
  logic [AgeWidth-1:0] bage_d, bage_q;
  logic [OwnerW-1:0] rown_d, rown_q;
  logic [CntW-1:0]   cnt_d, cnt_q;
  logic              page_hit;

  assign page_hit = (32'(cmd_i.page) == 32'(Idx));

  always_comb begin
    used_d  = used_q;
    bound_d = bound_q;
    own_d   = own_q;
    age_d   = age_q;
    ctl_d   = ctl_i;
    idx_d   = idx_i;
    bage_d  = age_i;
    rown_d  = owner_i;
    if (ctl_i.valid) begin
      case (cmd_i.action)
        ActAlloc, ActAllocOwn: begin
          if (!ctl_i.found && !used_q) begin
            used_d      = 1'b1;
            ctl_d.found = 1'b1;
            idx_d       = IdxW'(Idx);
            if (cmd_i.action == ActAllocOwn) begin
              own_d   = cmd_i.owner;
              bound_d = 1'b1;
            end
          end
        end
        ActFree: begin
          if (page_hit) used_d = 1'b0;
        end
        ActQuery: begin
          if (page_hit) begin
            ctl_d.q_used = used_q;
            rown_d       = own_q;
          end
        end
        ActVictim: begin
          // strict compare keeps the lowest index on equal ages
          if (bound_q && (!ctl_i.found || age_q < age_i)) begin
            ctl_d.found = 1'b1;
            idx_d       = IdxW'(Idx);
            bage_d      = age_q;
          end
        end
        ActSetAge: begin
          if (page_hit) age_d = cmd_age_i;
        end
        default: ;
      endcase
    end
    cnt_d = cnt_i + CntW'(!used_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= 1'b0;
      bound_q <= 1'b0;
      own_q   <= '0;
      age_q   <= '0;
      ctl_q   <= '0;
    end else begin
      used_q  <= used_d;
      bound_q <= bound_d;
      own_q   <= own_d;
      age_q   <= age_d;
      ctl_q   <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    bage_q <= bage_d;
    rown_q <= rown_d;
    cnt_q  <= cnt_d;
  end

  assign ctl_o   = ctl_q;
  assign idx_o   = idx_q;
  assign age_o   = bage_q;
  assign owner_o = rown_q;
  assign cnt_o   = cnt_q;

endmodule

// ===== hw/rtl/frame_allocator_lru_victim_unit.sv =====
// Frame allocator top level: command register, chain of frame cells, result register.
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+-----------------------------------------------
//   req_ch   | in  | valid / ready | action, page, owner, age
//   rsp_ch   | out | valid / ready | frame, is_used, frame_owner, free_count, any_free
//
// One item walks a search record down the chain one cell per cycle; the result then
// passes through the result register into the output register. Requests are
// taken only between items.
// Reset clears every frame (free, unbound, owner 0, age 0) at once; no sweep.
// A stalled response holds in the output register; the next request may
// transfer meanwhile, and its result waits until the register drains.
module frame_allocator_lru_victim_unit #(
  parameter int FRAMES    = fav_pkg::DefFrames,
  parameter int AGE_WIDTH = fav_pkg::DefAgeWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fav_req_if.sink    req_ch,
  fav_rsp_if.source  rsp_ch
);
  import fav_pkg::*;

  localparam int IdxW = $clog2(FRAMES);
  localparam int CntW = $clog2(FRAMES + 1);

  state_e state_q, state_d;

  cmd_t                 cmd_q;
  logic [AGE_WIDTH-1:0] cmd_age_q;
  logic                 start_q;
  logic                 req_xfer;

  rec_ctl_t             ctl_w   [FRAMES+1];
  logic [IdxW-1:0]      idx_w   [FRAMES+1];
  logic [AGE_WIDTH-1:0] age_w   [FRAMES+1];
  logic [OwnerW-1:0]    own_w   [FRAMES+1];
  logic [CntW-1:0]      cnt_w   [FRAMES+1];

  rec_ctl_t             res_ctl_q;
  logic [IdxW-1:0]      res_idx_q;
  logic [OwnerW-1:0]    res_own_q;
  logic [CntW-1:0]      res_cnt_q;
  logic                 res_load, out_load;

  logic                 out_valid_q;
  logic [FrameW-1:0]    out_frame_q;
  logic                 out_used_q;
  logic [OwnerW-1:0]    out_own_q;
  logic [CntW-1:0]      out_cnt_q;

  assign req_ch.ready = (state_q == StIdle);
  assign req_xfer     = req_ch.valid && req_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
    end else begin
      start_q <= req_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      cmd_q.action <= req_ch.action;
      cmd_q.page   <= req_ch.page;
      cmd_q.owner  <= req_ch.owner;
      cmd_age_q    <= AGE_WIDTH'(req_ch.age);
    end
  end

  // head of the chain: a fresh record with nothing found and no frame counted
  assign ctl_w[0] = '{valid: start_q, found: 1'b0, q_used: 1'b0};
  assign idx_w[0] = '0;
  assign age_w[0] = '0;
  assign own_w[0] = '0;
  assign cnt_w[0] = '0;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    fav_cell #(
      .Frames   (FRAMES),
      .AgeWidth (AGE_WIDTH),
      .Idx      (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd_q),
      .cmd_age_i (cmd_age_q),
      .ctl_i     (ctl_w[i]),
      .idx_i     (idx_w[i]),
      .age_i     (age_w[i]),
      .owner_i   (own_w[i]),
      .cnt_i     (cnt_w[i]),
      .ctl_o     (ctl_w[i+1]),
      .idx_o     (idx_w[i+1]),
      .age_o     (age_w[i+1]),
      .owner_o   (own_w[i+1]),
      .cnt_o     (cnt_w[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    res_load = 1'b0;
    out_load = 1'b0;
    case (state_q)
      StIdle: begin
        if (req_xfer) state_d = StScan;
      end
      StScan: begin
        if (ctl_w[FRAMES].valid) begin
          res_load = 1'b1;
          state_d  = StWait;
        end
      end
      StWait: begin
        if (!out_valid_q || rsp_ch.ready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ctl_q <= '0;
    end else if (res_load) begin
      res_ctl_q <= ctl_w[FRAMES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_idx_q <= idx_w[FRAMES];
      res_own_q <= own_w[FRAMES];
      res_cnt_q <= cnt_w[FRAMES];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_frame_q <= res_ctl_q.found ? FrameW'(res_idx_q) : NoFrame;
      out_used_q  <= res_ctl_q.q_used;
      out_own_q   <= res_own_q;
      out_cnt_q   <= res_cnt_q;
    end
  end

  assign rsp_ch.valid       = out_valid_q;
  assign rsp_ch.frame       = out_frame_q;
  assign rsp_ch.is_used     = out_used_q;
  assign rsp_ch.frame_owner = out_own_q;
  assign rsp_ch.free_count  = FrameW'(out_cnt_q);
  assign rsp_ch.any_free    = (out_cnt_q != '0);

  a_tail_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_w[FRAMES].valid |-> state_q == StScan)
    else $error("search record left the chain outside a scan");

  a_start_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |=> !start_q && state_q == StScan)
    else $error("scan start not a single pulse");

  a_found_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_w[FRAMES].valid && ctl_w[FRAMES].found |-> 32'(idx_w[FRAMES]) < FRAMES)
    else $error("found frame index out of range");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> 32'(out_cnt_q) <= FRAMES)
    else $error("free count exceeds frame count");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rsp_ch.ready |=> out_valid_q && $stable(out_frame_q))
    else $error("stalled response changed");

endmodule

// ===== sim/fav_alloc_checker.sv =====
`timescale 1ns / 100ps
// Response checker for the frame allocator: tracks the frame tables and compares every response.
module fav_alloc_checker
  import fav_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  fav_req_if          req_ch,
  fav_rsp_if          rsp_ch,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned refused_o
);

  localparam int Frames      = DefFrames;
  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [FrameW-1:0] frame;
    logic              is_used;
    logic [OwnerW-1:0] owner;
    logic [FrameW-1:0] free_cnt;
    logic              any_free;
  } frame_rsp_t;

  logic [Frames-1:0]      used_map;
  logic [Frames-1:0]      bound_map;
  logic [OwnerW-1:0]      owner_tbl [Frames];
  logic [DefAgeWidth-1:0] age_tbl   [Frames];

  frame_rsp_t  predicted_rsp [$];
  int unsigned mismatch_n;
  int unsigned checked_n;
  int unsigned refused_n;

  // applies one request to the frame tables and returns the response it must produce
  task automatic frame_table_step(input logic [ActionW-1:0] act,
                                  input logic [PageW-1:0] page,
                                  input logic [OwnerW-1:0] owner,
                                  input logic [AgeInW-1:0] age,
                                  output frame_rsp_t rsp);
    logic                   hit;
    logic [DefAgeWidth-1:0] least;
    int                     free_n;
    int                     i;
    rsp       = '0;
    rsp.frame = NoFrame;
    hit       = 1'b0;
    least     = '0;
    free_n    = 0;
    case (act)
      ActAlloc, ActAllocOwn: begin
        for (i = 0; i < Frames; i++) begin
          if (!hit && !used_map[i]) begin
            hit         = 1'b1;
            used_map[i] = 1'b1;
            rsp.frame   = FrameW'(i);
            if (act == ActAllocOwn) begin
              owner_tbl[i] = owner;
              bound_map[i] = 1'b1;
            end
          end
        end
        if (!hit) refused_n++;
      end
      ActFree: begin
        if (page < Frames) used_map[page] = 1'b0;
      end
      ActQuery: begin
        if (page < Frames) begin
          rsp.is_used = used_map[page];
          rsp.owner   = owner_tbl[page];
        end
      end
      ActVictim: begin
        // strict less-than keeps the lowest index on equal ages
        for (i = 0; i < Frames; i++) begin
          if (bound_map[i] && (!hit || age_tbl[i] < least)) begin
            hit       = 1'b1;
            least     = age_tbl[i];
            rsp.frame = FrameW'(i);
          end
        end
      end
      ActSetAge: begin
        if (page < Frames) age_tbl[page] = age[DefAgeWidth-1:0];
      end
      default: ;
    endcase
    for (i = 0; i < Frames; i++) begin
      if (!used_map[i]) free_n++;
    end
    rsp.free_cnt = FrameW'(free_n);
    rsp.any_free = (free_n != 0);
  endtask

  task automatic check_response();
    frame_rsp_t want;
    frame_rsp_t got;
    got.frame    = rsp_ch.frame;
    got.is_used  = rsp_ch.is_used;
    got.owner    = rsp_ch.frame_owner;
    got.free_cnt = rsp_ch.free_count;
    got.any_free = rsp_ch.any_free;
    if (predicted_rsp.size() == 0) begin
      mismatch_n++;
      if (mismatch_n <= ReportLimit) begin
        $display("%0t: response with no request outstanding: frame %0d free %0d",
                 $time, $signed(got.frame), got.free_cnt);
      end
    end else begin
      want = predicted_rsp.pop_front();
      checked_n++;
      if (got.frame !== want.frame || got.is_used !== want.is_used ||
          got.owner !== want.owner || got.free_cnt !== want.free_cnt ||
          got.any_free !== want.any_free) begin
        mismatch_n++;
        if (mismatch_n <= ReportLimit) begin
          $display("%0t: mismatch (exp/got) frame %0d/%0d used %0b/%0b owner %0d/%0d",
                   $time, $signed(want.frame), $signed(got.frame), want.is_used,
                   got.is_used, want.owner, got.owner);
          $display("    free_count %0d/%0d any_free %0b/%0b",
                   want.free_cnt, got.free_cnt, want.any_free, got.any_free);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_rsp_t next_rsp;
    int         idx;
    if (!rst_ni) begin
      used_map  = '0;
      bound_map = '0;
      for (idx = 0; idx < Frames; idx++) begin
        owner_tbl[idx] = '0;
        age_tbl[idx]   = '0;
      end
      predicted_rsp.delete();
      mismatch_n = 0;
      checked_n  = 0;
      refused_n  = 0;
    end else begin
      // a response always belongs to an older request, so drain before pushing
      if (rsp_ch.valid && rsp_ch.ready) check_response();
      if (req_ch.valid && req_ch.ready) begin
        frame_table_step(req_ch.action, req_ch.page, req_ch.owner, req_ch.age, next_rsp);
        predicted_rsp.push_back(next_rsp);
      end
    end
    mismatches_o <= mismatch_n;
    pending_o    <= predicted_rsp.size();
    checked_o    <= checked_n;
    refused_o    <= refused_n;
  end

endmodule

// ===== sim/tb_frame_allocator_lru_victim_unit.sv =====
`timescale 1ns / 100ps
// Top of the frame allocator testbench: clock, reset, request and response traffic, verdict.
module tb_frame_allocator_lru_victim_unit;
  import fav_pkg::*;

  localparam int Frames        = DefFrames;
  localparam int Items         = 1300;
  // the watchdog limit leaves room for a 75% receiver stall or sender gap
  localparam int WatchdogLimit = 3000;
  localparam int SettleCycles  = 2 * (Frames + 3);
  localparam int IdlePct  [4]  = '{0, 75, 0, 35};
  localparam int StallPct [4]  = '{0, 0, 75, 35};

  localparam logic [ActionW-1:0] ActUnused6 = 3'd6;
  localparam logic [ActionW-1:0] ActUnused7 = 3'd7;

  typedef enum int {MixFill, MixDrain, MixAny} mix_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  fav_req_if req_ch ();
  fav_rsp_if rsp_ch ();

  int unsigned mismatch_n;
  int unsigned pending_n;
  int unsigned checked_n;
  int unsigned refused_n;

  int          idle_pct;
  int          stall_pct;
  int unsigned sent_n;
  int unsigned act_sent [8];
  int unsigned idle_cycles;

  frame_allocator_lru_victim_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_ch (req_ch),
    .rsp_ch (rsp_ch)
  );

  fav_alloc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_ch       (req_ch),
    .rsp_ch       (rsp_ch),
    .mismatches_o (mismatch_n),
    .pending_o    (pending_n),
    .checked_o    (checked_n),
    .refused_o    (refused_n)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles, %0d responses outstanding",
               WatchdogLimit, pending_n);
      $display("tb_frame_allocator_lru_victim_unit: done, errors");
      $finish;
    end
  end

  // valid stays up after a transfer unless a gap or a pause follows
  task automatic send_item(input logic [ActionW-1:0] act, input logic [PageW-1:0] page,
                           input logic [OwnerW-1:0] owner, input logic [AgeInW-1:0] age);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.page   <= page;
    req_ch.owner  <= owner;
    req_ch.age    <= age;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sent_n++;
    act_sent[act]++;
  endtask

  task automatic drain_pause();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (pending_n != 0) @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_item(ActVictim,   5'd0,  8'h00, 16'h0000);  // nothing bound yet
    send_item(ActQuery,    5'd31, 8'hFF, 16'hFFFF);
    send_item(ActAlloc,    5'd31, 8'hFF, 16'hFFFF);
    send_item(ActAllocOwn, 5'd0,  8'hFF, 16'h0000);
    send_item(ActAllocOwn, 5'd0,  8'h00, 16'h0000);
    send_item(ActQuery,    5'd1,  8'h00, 16'h0000);
    send_item(ActSetAge,   5'd1,  8'h00, 16'hFFFF);
    send_item(ActSetAge,   5'd2,  8'h00, 16'hFFFF);
    send_item(ActVictim,   5'd0,  8'h00, 16'h0000);  // tie on age, lowest index
    send_item(ActSetAge,   5'd2,  8'h00, 16'h0000);
    send_item(ActVictim,   5'd0,  8'h00, 16'h0000);
    send_item(ActFree,     5'd2,  8'h00, 16'h0000);
    send_item(ActQuery,    5'd2,  8'h00, 16'h0000);  // owner survives the free
    send_item(ActVictim,   5'd0,  8'h00, 16'h0000);  // freed frame stays bound
    send_item(ActFree,     5'd31, 8'hFF, 16'hFFFF);  // frame never used
    send_item(ActSetAge,   5'd31, 8'h00, 16'h5555);  // unbound frame
    send_item(ActUnused6,  5'd31, 8'hFF, 16'hFFFF);
    send_item(ActUnused7,  5'd0,  8'hFF, 16'hFFFF);
    send_item(ActAlloc,    5'd0,  8'h00, 16'h0000);
    send_item(ActFree,     5'd0,  8'h00, 16'h0000);
    send_item(ActQuery,    5'd0,  8'h00, 16'h0000);
    send_item(ActAllocOwn, 5'd0,  8'hAA, 16'h0000);
  endtask

  task automatic send_random(input mix_e mix);
    int                 roll;
    logic [ActionW-1:0] act;
    logic [AgeInW-1:0]  age;
    roll = $urandom_range(99);
    case (mix)
      MixFill: begin
        act = roll < 35 ? ActAlloc : roll < 70 ? ActAllocOwn : roll < 80 ? ActVictim :
              roll < 90 ? ActSetAge : roll < 95 ? ActQuery : ActFree;
      end
      MixDrain: begin
        act = roll < 60 ? ActFree : roll < 70 ? ActAlloc : roll < 85 ? ActQuery :
              roll < 95 ? ActVictim : ActSetAge;
      end
      default: begin
        act = roll < 3 ? ActUnused6 : roll < 6 ? ActUnused7 :
              ActionW'($urandom_range(int'(ActSetAge)));
      end
    endcase
    // small ages make ties for the victim search common
    case ($urandom_range(2))
      0:       age = $urandom_range(1) ? {AgeInW{1'b1}} : {AgeInW{1'b0}};
      1:       age = AgeInW'($urandom_range(3));
      default: age = AgeInW'($urandom());
    endcase
    send_item(act, PageW'($urandom()), OwnerW'($urandom()), age);
  endtask

  initial begin
    int   ph;
    int   k;
    int   len;
    int   quota;
    mix_e mix;
    rst_ni        = 1'b0;
    req_ch.valid  = 1'b0;
    req_ch.action = ActAlloc;
    req_ch.page   = '0;
    req_ch.owner  = '0;
    req_ch.age    = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    sent_n        = 0;
    for (k = 0; k < 8; k++) act_sent[k] = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // the first episode favours allocs so the frames fill and refused allocs show up early
    mix = MixFill;
    for (ph = 0; ph < 4; ph++) begin
      idle_pct  = IdlePct[ph];
      stall_pct = StallPct[ph];
      if (ph == 0) run_directed();
      quota = (Items * (ph + 1)) / 4;
      while (sent_n < quota) begin
        len = $urandom_range(60, 20);
        for (k = 0; k < len && sent_n < quota; k++) send_random(mix);
        if ($urandom_range(3) == 0) drain_pause();
        mix = mix_e'($urandom_range(2));
      end
      drain_pause();
    end

    repeat (SettleCycles) @(posedge clk_i);

    $display("summary: %0d requests (alloc %0d, alloc+owner %0d, free %0d, query %0d,",
             sent_n, act_sent[ActAlloc], act_sent[ActAllocOwn], act_sent[ActFree],
             act_sent[ActQuery]);
    $display("  victim %0d, set-age %0d, unknown %0d); %0d responses checked, %0d refused allocs",
             act_sent[ActVictim], act_sent[ActSetAge],
             act_sent[ActUnused6] + act_sent[ActUnused7], checked_n, refused_n);
    if (mismatch_n == 0 && pending_n == 0) begin
      $display("tb_frame_allocator_lru_victim_unit: done, clean");
    end else begin
      $display("tb_frame_allocator_lru_victim_unit: done, errors");
    end
    $finish;
  end

endmodule
